// File: hw/rtl/range_distinct_count_unit_macros.svh
// Assertion helpers for the checker in rdc_check.sv.
`ifndef RANGE_DISTINCT_COUNT_UNIT_MACROS_SVH
`define RANGE_DISTINCT_COUNT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define RDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define RDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/rdc_pkg.sv
package rdc_pkg;

	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned RANGE_W    = 10;
	localparam int unsigned COUNT_W    = 11;
	localparam int unsigned CMD_W      = 2;
	localparam int unsigned IN_TDATA_W = 56;
	localparam int unsigned OUT_TDATA_W = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_QUERY  = 2'd2
	} cmd_t;

	// Control into the address walker.
	typedef struct packed {
		logic go;
		logic up;
		logic stop;
	} scan_ctl_t;

	// Status out of the address walker.
	typedef struct packed {
		logic rd_en;
		logic data_valid;
		logic data_last;
	} scan_sts_t;

endpackage

// File: hw/rtl/rdc_ram.sv
module rdc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: hw/rtl/rdc_scan.sv
module rdc_scan #(
	parameter int AW = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rdc_pkg::scan_ctl_t  ctl,
	input  logic [AW-1:0]       from,
	input  logic [AW-1:0]       to,
	output logic [AW-1:0]       rd_addr,
	output logic [AW-1:0]       data_addr,
	output rdc_pkg::scan_sts_t  sts
);

	logic          run_q;
	logic          pend_q;
	logic          up_q;
	logic          last_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] to_q;
	logic [AW-1:0] paddr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			pend_q <= 1'b0;
		end else if (ctl.go) begin
			run_q  <= 1'b1;
			pend_q <= 1'b0;
		end else if (ctl.stop) begin
			run_q  <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			pend_q <= run_q;
			if (run_q && addr_q == to_q) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			addr_q <= from;
			to_q   <= to;
			up_q   <= ctl.up;
		end else begin
			paddr_q <= addr_q;
			last_q  <= (addr_q == to_q);
			if (run_q && addr_q != to_q) begin
				addr_q <= up_q ? addr_q + 1'b1 : addr_q - 1'b1;
			end
		end
	end

	assign rd_addr        = addr_q;
	assign data_addr      = paddr_q;
	assign sts.rd_en      = run_q;
	assign sts.data_valid = pend_q;
	assign sts.data_last  = last_q;

endmodule

// File: hw/rtl/range_distinct_count_unit.sv
// Range distinct count unit.
// Input stream s_*: s_tuser carries the command (clear, append, query);
// s_tdata carries the value to append and the query bounds. Output stream m_*
// carries one result per query and per append into a full array.
// A clear returns no result. An append into an empty array is written
// without a walk. An append at position p > 0 walks the stored values from
// p-1 down to 0, one value memory read per cycle, and stops at the first
// match, with no result.
// A query over [s, e] reads the previous-occurrence memory once per position
// and counts the first occurrences: e-s+1 reads, with the count going
// through the result register into the output register. Queries that fail
// the bound checks, or that hold one position or none, and appends into a
// full array skip the walk and go through the result and output registers. The
// read port of each memory is walked by one address counter; s_tready is
// high only while the sequencer is idle.
// The output register holds a result while m_tready is low; the block takes
// the next transaction meanwhile, and a second result waits in the
// sequencer until the register frees.
// Reset clears the fill length, the sequencer and the output valid. The
// memories need no clearing: only positions below the fill length are read.
module range_distinct_count_unit #(
	parameter int MAX_LEN     = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// value [31:0], range_start [41:32], range_end [51:42], zero pad
	input  logic [rdc_pkg::IN_TDATA_W-1:0]    s_tdata,
	// command [1:0]
	input  logic [rdc_pkg::CMD_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// distinct_count [10:0], zero pad
	output logic [rdc_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// index_error [0]
	output logic                              m_tuser
);

	localparam int AW  = $clog2(MAX_LEN);
	localparam int LW  = $clog2(MAX_LEN + 1);
	localparam int IW  = (LW > rdc_pkg::RANGE_W) ? LW : rdc_pkg::RANGE_W;
	localparam int VEW = (VALUE_WIDTH > rdc_pkg::VALUE_W) ? VALUE_WIDTH : rdc_pkg::VALUE_W;
	localparam int CW  = rdc_pkg::COUNT_W;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_APPEND = 4'b0010,
		ST_QUERY  = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t        state_q, state_d;
	logic [LW-1:0] fill_q;
	logic          out_valid_q;
	logic [CW-1:0] out_cnt_q;
	logic          out_err_q;

	logic [VALUE_WIDTH-1:0] val_q;
	logic [AW-1:0]          pos_q;
	logic [AW-1:0]          sidx_q;
	logic [CW-1:0]          res_cnt_q, res_cnt_d;
	logic                   res_err_q, res_err_d;
	logic                   res_load;

	// Field unpacking.
	rdc_pkg::cmd_t          cmd_in;
	logic [VEW-1:0]         val_ext;
	logic [VALUE_WIDTH-1:0] val_in;
	logic [IW-1:0]          rs_w, re_w, fill_w;
	logic                   accept, full, empty, out_free;

	assign cmd_in   = rdc_pkg::cmd_t'(s_tuser);
	assign val_ext  = VEW'(s_tdata[31:0]);
	assign val_in   = val_ext[VALUE_WIDTH-1:0];
	assign rs_w     = IW'(s_tdata[41:32]);
	assign re_w     = IW'(s_tdata[51:42]);
	assign fill_w   = IW'(fill_q);
	assign full     = (fill_q == LW'(MAX_LEN));
	assign empty    = (fill_q == '0);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// Address walker and memories.
	rdc_pkg::scan_ctl_t scan_ctl;
	rdc_pkg::scan_sts_t scan_sts;
	logic [AW-1:0]      scan_from, scan_to, rd_addr, data_addr;

	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [VALUE_WIDTH-1:0] wr_val;
	logic [AW:0]            wr_prev;
	logic [VALUE_WIDTH-1:0] val_rd;
	logic [AW:0]            prev_rd;
	logic                   hit, repeat_pos;

	rdc_scan #(.AW(AW)) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.from      (scan_from),
		.to        (scan_to),
		.rd_addr   (rd_addr),
		.data_addr (data_addr),
		.sts       (scan_sts)
	);

	rdc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_LEN)) u_value_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_val),
		.rd_en   (scan_sts.rd_en),
		.rd_addr (rd_addr),
		.rd_data (val_rd)
	);

	// Entry: valid bit on top, index of the previous occurrence below.
	rdc_ram #(.WIDTH(AW + 1), .DEPTH(MAX_LEN)) u_prev_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_prev),
		.rd_en   (scan_sts.rd_en),
		.rd_addr (rd_addr),
		.rd_data (prev_rd)
	);

	// The compares: value equality while appending, repeat test while querying.
	assign hit        = scan_sts.data_valid && (val_rd == val_q);
	assign repeat_pos = prev_rd[AW] && (prev_rd[AW-1:0] >= sidx_q);

	always_comb begin
		state_d       = state_q;
		scan_ctl      = '0;
		scan_from     = '0;
		scan_to       = '0;
		wr_en         = 1'b0;
		wr_addr       = pos_q;
		wr_val        = val_q;
		wr_prev       = {hit, data_addr};
		res_load      = 1'b0;
		res_cnt_d     = res_cnt_q;
		res_err_d     = res_err_q;
		unique case (state_q)
			ST_IDLE: begin
				wr_addr = fill_q[AW-1:0];
				wr_val  = val_in;
				wr_prev = '0;
				if (accept) begin
					unique case (cmd_in)
						rdc_pkg::CMD_APPEND: begin
							priority if (full) begin
								res_load  = 1'b1;
								res_cnt_d = '0;
								res_err_d = 1'b1;
								state_d   = ST_RESULT;
							end else if (empty) begin
								wr_en = 1'b1;
							end else begin
								scan_ctl.go = 1'b1;
								scan_from   = fill_q[AW-1:0] - 1'b1;
								scan_to     = '0;
								state_d     = ST_APPEND;
							end
						end
						rdc_pkg::CMD_QUERY: begin
							res_load  = 1'b1;
							res_err_d = 1'b0;
							priority if (rs_w >= fill_w || re_w >= fill_w) begin
								res_cnt_d = '0;
								res_err_d = 1'b1;
								state_d   = ST_RESULT;
							end else if (rs_w == re_w) begin
								res_cnt_d = CW'(1);
								state_d   = ST_RESULT;
							end else if (rs_w > re_w) begin
								res_cnt_d = '0;
								state_d   = ST_RESULT;
							end else begin
								res_cnt_d    = '0;
								scan_ctl.go  = 1'b1;
								scan_ctl.up  = 1'b1;
								scan_from    = rs_w[AW-1:0];
								scan_to      = re_w[AW-1:0];
								state_d      = ST_QUERY;
							end
						end
						default: begin
							// clear and unused codes: nothing to do here
						end
					endcase
				end
			end
			ST_APPEND: begin
				if (scan_sts.data_valid && (hit || scan_sts.data_last)) begin
					wr_en         = 1'b1;
					scan_ctl.stop = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_QUERY: begin
				if (scan_sts.data_valid) begin
					res_load  = 1'b1;
					res_cnt_d = res_cnt_q + CW'(!repeat_pos);
					if (scan_sts.data_last) begin
						state_d = ST_RESULT;
					end
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// drop the array on clear, advance on every stored append
			if (accept && cmd_in == rdc_pkg::CMD_CLEAR) begin
				fill_q <= '0;
			end else if (wr_en) begin
				fill_q <= fill_q + 1'b1;
			end
			if (state_q == ST_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q  <= val_in;
			pos_q  <= fill_q[AW-1:0];
			sidx_q <= rs_w[AW-1:0];
		end
		if (res_load) begin
			res_cnt_q <= res_cnt_d;
			res_err_q <= res_err_d;
		end
		// hold the result until the output register frees
		if (state_q == ST_RESULT && out_free) begin
			out_cnt_q <= res_cnt_q;
			out_err_q <= res_err_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(rdc_pkg::OUT_TDATA_W - CW){1'b0}}, out_cnt_q};
	assign m_tuser  = out_err_q;

endmodule

// File: hw/rtl/rdc_check.sv
`include "range_distinct_count_unit_macros.svh"

module rdc_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [rdc_pkg::CMD_W-1:0]       s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [rdc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                            m_tuser
);

	// A stalled result stays offered.
	`RDC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

	// An error result carries a zero count.
	`RDC_ASSERT_NOW(a_err_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0)

	// No range holds more than 1024 distinct values.
	`RDC_ASSERT_NOW(a_cnt_max, clk, arst_n, m_tvalid, m_tdata[10:0] <= 11'd1024)

	// A clear completes in its own cycle and leaves the input open.
	`RDC_ASSERT_NEXT(a_clear_fast, clk, arst_n,
		s_tvalid && s_tready && s_tuser == rdc_pkg::CMD_CLEAR, s_tready)

endmodule

bind range_distinct_count_unit rdc_check u_rdc_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: tb/sv/tb.sv
module tb;

	localparam int DEPTH = 1024;
	localparam int CW    = rdc_pkg::COUNT_W;
	localparam int RW    = rdc_pkg::RANGE_W;
	localparam logic [rdc_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;
	// longest walk of an append or a query over the whole array, plus margin
	localparam int SETTLE_CYCLES = DEPTH + 100;

	typedef struct {
		logic [rdc_pkg::COUNT_W-1:0] count;
		logic                        flag;
	} answer_t;

	// Tracks the array contents and the answers the block owes, in order.
	class distinct_count_board;
		logic [rdc_pkg::VALUE_W-1:0] stored_value[DEPTH];
		logic [rdc_pkg::COUNT_W-1:0] prior_index[DEPTH];
		bit                          has_prior[DEPTH];
		int unsigned                 length;
		answer_t                     pending[$];
		int unsigned                 mismatches;

		function new();
			length = 0;
			mismatches = 0;
		endfunction

		// Queue one answer behind the ones already owed.
		function void owe_answer(answer_t ans);
			pending.insert(pending.size(), ans);
		endfunction

		// Advance the array model by one accepted transaction; queue any answer.
		function void note_command(logic [rdc_pkg::CMD_W-1:0] cmd,
			logic [rdc_pkg::VALUE_W-1:0] value,
			logic [rdc_pkg::RANGE_W-1:0] first, logic [rdc_pkg::RANGE_W-1:0] last);
			answer_t ans;
			int unsigned repeats;
			int p;
			ans.count = '0;
			ans.flag  = 1'b0;
			case (cmd)
			rdc_pkg::CMD_CLEAR: length = 0;
			rdc_pkg::CMD_APPEND: begin
				if (length >= DEPTH) begin
					// full array: nothing stored, error answer
					ans.flag = 1'b1;
					owe_answer(ans);
				end else begin
					has_prior[length]   = 1'b0;
					prior_index[length] = '0;
					// latest earlier position holding the same value
					for (p = int'(length) - 1; p >= 0; p--) begin
						if (stored_value[p] == value) begin
							has_prior[length]   = 1'b1;
							prior_index[length] = p[rdc_pkg::COUNT_W-1:0];
							break;
						end
					end
					stored_value[length] = value;
					length++;
				end
			end
			rdc_pkg::CMD_QUERY: begin
				if (first >= length || last >= length) begin
					ans.flag = 1'b1;
				end else if (first == last) begin
					ans.count = CW'(1);
				end else if (first < last) begin
					// drop every position whose value already showed up inside the range
					repeats = 0;
					for (p = first; p <= last; p++)
						if (has_prior[p] && prior_index[p] >= first)
							repeats++;
					ans.count = CW'(last - first + 1 - repeats);
				end
				owe_answer(ans);
			end
			default: ;
			endcase
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s", $time, msg);
		endfunction

		// Compare one accepted result with the oldest answer owed.
		function void check_answer(logic [rdc_pkg::COUNT_W-1:0] count, logic flag);
			answer_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result: count %0d error %0b", count, flag));
				return;
			end
			want = pending.pop_front();
			if (count !== want.count || flag !== want.flag)
				report($sformatf({"result mismatch: expected count %0d error %0b,",
					" got count %0d error %0b"},
					want.count, want.flag, count, flag));
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [rdc_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic [rdc_pkg::CMD_W-1:0]       s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [rdc_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                            m_tuser;

	distinct_count_board board = new();
	int unsigned commands_sent = 0;
	int unsigned answers_taken = 0;

	range_distinct_count_unit #(
		.MAX_LEN    (DEPTH),
		.VALUE_WIDTH(rdc_pkg::VALUE_W)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Offer one transaction after a random gap; hold it until accepted.
	task automatic send_command(input logic [rdc_pkg::CMD_W-1:0] cmd,
		input logic [rdc_pkg::VALUE_W-1:0] value = '0,
		input logic [rdc_pkg::RANGE_W-1:0] first = '0,
		input logic [rdc_pkg::RANGE_W-1:0] last = '0);
		int unsigned gap;
		// every fifth stretch of 48 transactions runs back to back
		gap = ((commands_sent / 48) % 5 == 4) ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{(rdc_pkg::IN_TDATA_W - rdc_pkg::VALUE_W - 2 * rdc_pkg::RANGE_W){1'b0}},
			last, first, value};
		do @(posedge clk); while (!s_tready);
		board.note_command(cmd, value, first, last);
		if (cmd != CMD_RESERVED)
			commands_sent++;
	endtask

	// Mostly well-formed ranges over the loaded part, plus noise and ignored commands.
	task automatic ask_random_range();
		int unsigned len, pick, first, last;
		len  = board.length;
		pick = $urandom_range(0, 19);
		if (pick == 19) begin
			send_command(CMD_RESERVED, $urandom(), RW'($urandom()), RW'($urandom()));
			return;
		end
		if (pick == 18 || len == 0) begin
			first = $urandom_range(0, DEPTH - 1);
			last  = $urandom_range(0, DEPTH - 1);
		end else if (pick >= 16 && len >= 2) begin
			last  = $urandom_range(0, len - 2);
			first = $urandom_range(last + 1, len - 1);
		end else if (pick >= 14) begin
			first = $urandom_range(0, len - 1);
			last  = first;
		end else begin
			first = $urandom_range(0, len - 1);
			last  = $urandom_range(first, len - 1);
		end
		send_command(rdc_pkg::CMD_QUERY, $urandom(), first[RW-1:0], last[RW-1:0]);
	endtask

	// Result side: random stalls, one long hold-off to back the block up.
	initial begin : result_sink
		int unsigned gap;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (answers_taken == 60 && !held) begin
				gap  = 400;
				held = 1'b1;
			end else begin
				gap = ((answers_taken / 40) % 5 == 4) ? 0 : $urandom_range(0, 19);
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			board.check_answer(m_tdata[CW-1:0], m_tuser);
			answers_taken++;
		end
	end

	initial begin : stimulus
		int unsigned n, alphabet, random_start, i;
		logic [rdc_pkg::VALUE_W-1:0] base;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty array, value extremes, repeats, every query shape
		send_command(rdc_pkg::CMD_QUERY, '0, 10'd0, 10'd0);
		send_command(rdc_pkg::CMD_APPEND, 32'h7FFF_FFFF);
		send_command(rdc_pkg::CMD_APPEND, 32'h8000_0000);
		send_command(rdc_pkg::CMD_APPEND, 32'h0000_0000);
		send_command(rdc_pkg::CMD_APPEND, 32'hFFFF_FFFF);
		send_command(rdc_pkg::CMD_APPEND, 32'h8000_0000);
		send_command(rdc_pkg::CMD_APPEND, 32'hFFFF_FFFF);
		send_command(rdc_pkg::CMD_APPEND, 32'h7FFF_FFFF);
		send_command(rdc_pkg::CMD_QUERY, '0, 10'd0, 10'd6);
		send_command(rdc_pkg::CMD_QUERY, '0, 10'd2, 10'd5);
		send_command(rdc_pkg::CMD_QUERY, '0, 10'd3, 10'd3);
		send_command(rdc_pkg::CMD_QUERY, '0, 10'd5, 10'd1);
		send_command(rdc_pkg::CMD_QUERY, '0, 10'd0, 10'd7);
		send_command(rdc_pkg::CMD_QUERY, '0, 10'd7, 10'd0);
		send_command(rdc_pkg::CMD_QUERY, '0, 10'd1023, 10'd1023);
		send_command(CMD_RESERVED, 32'hFFFF_FFFF, 10'd1023, 10'd1023);
		send_command(rdc_pkg::CMD_CLEAR);
		send_command(rdc_pkg::CMD_QUERY, '0, 10'd0, 10'd0);
		send_command(rdc_pkg::CMD_APPEND, 32'd5);
		send_command(rdc_pkg::CMD_QUERY, '0, 10'd0, 10'd0);

		// random: short arrays over small alphabets, queries mixed in
		random_start = commands_sent;
		while (commands_sent < random_start + 720) begin
			send_command(rdc_pkg::CMD_CLEAR);
			n        = $urandom_range(1, 40);
			alphabet = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
			base     = $urandom();
			for (i = 0; i < n; i++) begin
				if ($urandom_range(0, 49) == 0)
					send_command(rdc_pkg::CMD_CLEAR);
				send_command(rdc_pkg::CMD_APPEND,
					(alphabet == 0) ? $urandom() : base + $urandom_range(0, alphabet - 1));
				if ($urandom_range(0, 2) == 0)
					ask_random_range();
			end
			repeat ($urandom_range(2, 6)) ask_random_range();
		end

		s_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("range_distinct_count_unit test passed");
		else
			$display("range_distinct_count_unit test failed");
		$finish;
	end

	initial begin : watchdog
		#40_000_000;
		$display("range_distinct_count_unit test failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_ram.sv
hw/rtl/rdc_scan.sv
hw/rtl/range_distinct_count_unit.sv
hw/rtl/rdc_check.sv
tb/sv/tb.sv
